// File: src/ipv6p_pkg.sv
// Shared types and constants for the IPv6 text address parser.
// Holds the classified character item and the result item layouts.
// No dependencies.
`timescale 1ns / 1ps

package ipv6p_pkg;

	typedef enum logic [1:0] {
		KIND_HEX   = 2'd0,
		KIND_COLON = 2'd1,
		KIND_DOT   = 2'd2,
		KIND_BAD   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] val;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic        parse_error;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;

endpackage

// File: src/ipv6p_queue.sv
// Small first-in first-out queue built from registers.
// Used between the classifier and the parser, and for finished results.
// No dependencies.
`timescale 1ns / 1ps

module ipv6p_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/ipv6p_front.sv
// Character classifier: turns an ASCII character into a kind and digit value.
// Depends on ipv6p_pkg.
`timescale 1ns / 1ps

module ipv6p_front
	import ipv6p_pkg::*;
(
	input  logic [7:0] text_char,
	input  logic       last_char,
	output item_t      item
);

	always_comb begin
		item.last = last_char;
		item.val  = '0;
		item.kind = KIND_BAD;
		if (text_char >= 8'h30 && text_char <= 8'h39) begin
			item.kind = KIND_HEX;
			item.val  = text_char[3:0];
		end else if ((text_char >= 8'h61 && text_char <= 8'h66) ||
			(text_char >= 8'h41 && text_char <= 8'h46)) begin
			item.kind = KIND_HEX;
			item.val  = 4'(text_char[2:0] + 3'd1) + 4'd8;
		end else if (text_char == CHAR_COLON) begin
			item.kind = KIND_COLON;
		end else if (text_char == CHAR_DOT) begin
			item.kind = KIND_DOT;
		end
	end

endmodule

// File: src/ipv6p_back.sv
// Parser back end: group, gap and dotted tail state, one item per cycle unless a last
// item meets a full result queue. Builds the 128-bit result on the last character.
// Depends on ipv6p_pkg.
`timescale 1ns / 1ps

module ipv6p_back
	import ipv6p_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  item_t   in_item,
	output logic    in_take,
	output logic    res_push,
	output result_t res,
	input  logic    res_full
);

	typedef struct packed {
		logic [7:0][15:0] grp;
		logic [3:0]       gcnt;
		logic             gap;
		logic [3:0]       gidx;
		logic [15:0]      hex;
		logic [9:0]       dec;
		logic [2:0]       dcnt;
		logic [2:0]       ocnt;
		logic [7:0]       held;
		logic             f_colon;
		logic             f_hexlet;
		logic             f_started;
		logic             f_leading;
		logic             err;
	} st_t;

	function automatic st_t clear_token(st_t s_in);
		st_t s;
		s = s_in;
		s.hex      = '0;
		s.dec      = '0;
		s.dcnt     = '0;
		s.f_hexlet = 1'b0;
		return s;
	endfunction

	function automatic st_t take_group(st_t s_in);
		st_t s;
		s = s_in;
		if (s.gcnt[3]) begin
			s.err = 1'b1;
		end else begin
			s.grp[s.gcnt[2:0]] = s.hex;
			s.gcnt = s.gcnt + 4'd1;
			s = clear_token(s);
		end
		return s;
	endfunction

	function automatic st_t take_octet(st_t s_in);
		st_t s;
		s = s_in;
		if (s.dcnt == 3'd0 || s.dcnt > 3'd3 || s.f_hexlet || s.dec[9:8] != 2'b00 ||
			(s.dcnt == 3'd2 && s.dec < 10'd10) ||
			(s.dcnt == 3'd3 && s.dec < 10'd100)) begin
			s.err = 1'b1;
		end else if (s.ocnt[0]) begin
			if (s.gcnt[3]) begin
				s.err = 1'b1;
			end else begin
				s.grp[s.gcnt[2:0]] = {s.held, s.dec[7:0]};
				s.gcnt = s.gcnt + 4'd1;
				s.ocnt = s.ocnt + 3'd1;
				s = clear_token(s);
			end
		end else begin
			s.held = s.dec[7:0];
			s.ocnt = s.ocnt + 3'd1;
			s = clear_token(s);
		end
		return s;
	endfunction

	function automatic st_t take_char(st_t s_in, item_t it);
		st_t         s;
		logic        first;
		logic [13:0] dec_next;
		s = s_in;
		first = !s.f_started;
		s.f_started = 1'b1;
		dec_next = {1'b0, s.dec, 3'b000} + {3'b000, s.dec, 1'b0} + {10'd0, it.val};
		case (it.kind)
			KIND_HEX: begin
				if (s.f_leading) begin
					s.err = 1'b1;
				end else begin
					s.f_colon = 1'b0;
					if (it.val > 4'd9 && s.ocnt != 3'd0) begin
						s.err = 1'b1;
					end else begin
						if (it.val > 4'd9) begin
							s.f_hexlet = 1'b1;
						end
						if (s.dcnt >= ((s.ocnt != 3'd0) ? 3'd3 : 3'd4)) begin
							s.err = 1'b1;
						end else begin
							s.dcnt = s.dcnt + 3'd1;
							s.hex  = {s.hex[11:0], it.val};
							if (it.val <= 4'd9) begin
								s.dec = dec_next[9:0];
							end
						end
					end
				end
			end
			KIND_COLON: begin
				if (s.ocnt != 3'd0) begin
					s.err = 1'b1;
				end else if (s.dcnt != 3'd0) begin
					s = take_group(s);
					s.f_colon = 1'b1;
				end else if (s.f_colon) begin
					if (s.gap) begin
						s.err = 1'b1;
					end else begin
						s.gap       = 1'b1;
						s.gidx      = s.gcnt;
						s.f_colon   = 1'b0;
						s.f_leading = 1'b0;
					end
				end else if (first) begin
					s.f_colon   = 1'b1;
					s.f_leading = 1'b1;
				end else begin
					s.err = 1'b1;
				end
			end
			KIND_DOT: begin
				if ((s.ocnt == 3'd0 && s.gcnt > 4'd6) || s.ocnt >= 3'd3) begin
					s.err = 1'b1;
				end else begin
					s = take_octet(s);
				end
			end
			default: begin
				s.err = 1'b1;
			end
		endcase
		return s;
	endfunction

	function automatic st_t finish(st_t s_in);
		st_t s;
		s = s_in;
		if (s.ocnt != 3'd0) begin
			if (s.ocnt != 3'd3) begin
				s.err = 1'b1;
			end else begin
				s = take_octet(s);
			end
		end else if (s.dcnt != 3'd0) begin
			s = take_group(s);
		end else if (s.f_colon || !s.gap) begin
			s.err = 1'b1;
		end
		if (!s.err) begin
			if (s.gap ? (s.gcnt > 4'd7) : (s.gcnt != 4'd8)) begin
				s.err = 1'b1;
			end
		end
		return s;
	endfunction

	st_t              st_q;
	st_t              st_step;
	st_t              st_next;
	logic [7:0][15:0] addr;
	logic [3:0]       shift;
	logic [3:0]       pos;

	assign in_take  = in_valid && !(in_item.last && res_full);
	assign res_push = in_take && in_item.last;

	always_comb begin
		st_step = st_q;
		if (!st_step.err) begin
			st_step = take_char(st_step, in_item);
		end
		if (in_item.last && !st_step.err) begin
			st_step = finish(st_step);
		end
		st_next = in_item.last ? '0 : st_step;
	end

	always_comb begin
		addr  = '0;
		shift = 4'd8 - st_step.gcnt;
		pos   = '0;
		if (!st_step.err) begin
			for (int i = 0; i < 8; i++) begin
				if (4'(i) < st_step.gcnt) begin
					pos = (st_step.gap && 4'(i) >= st_step.gidx) ? 4'(i) + shift : 4'(i);
					addr[pos[2:0]] = st_step.grp[i];
				end
			end
		end
		res.addr_high   = {addr[0], addr[1], addr[2], addr[3]};
		res.addr_low    = {addr[4], addr[5], addr[6], addr[7]};
		res.parse_error = st_step.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_take) begin
			st_q <= st_next;
		end
	end

endmodule

// File: src/ipv6_text_address_parser.sv
// IPv6 text address parser top level: classifier, item queue, parser, result queue.
// With both queues empty, a last character is registered in the item queue, taken by
// the parser step, and its result is registered in the result queue for the ports.
// Throughput: one character per cycle, set by the parser step, while it does not stall.
// The parser stalls only when the result queue is full and the item is a last one.
// Reset (arst_n low, asynchronous) empties both queues and clears all parse state.
// Depends on ipv6p_pkg, ipv6p_front, ipv6p_queue and ipv6p_back.
`timescale 1ns / 1ps

module ipv6_text_address_parser
	import ipv6p_pkg::*;
#(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_char,
	input  logic        last_char,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low,
	output logic        parse_error
);

	item_t   front_item;
	item_t   mid_item;
	logic    mid_empty;
	logic    mid_take;
	logic    res_push;
	logic    res_full;
	result_t res;
	result_t out_res;

	ipv6p_front u_front (
		.text_char (text_char),
		.last_char (last_char),
		.item      (front_item)
	);

	ipv6p_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (mid_take),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	ipv6p_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_item  (mid_item),
		.in_take  (mid_take),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

	ipv6p_queue #(
		.WIDTH (RESULT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign addr_high   = out_res.addr_high;
	assign addr_low    = out_res.addr_low;
	assign parse_error = out_res.parse_error;

endmodule
